[rtl/sstat_pkg.sv]
package sstat_pkg;

  // Saturation point of the sample counter
  localparam logic [16:0] MAX_SAMPLES = 17'd65536;

  // Width of the shared add/subtract unit
  localparam int ALU_W = 64;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } sstat_in_t;

  typedef struct packed {
    logic [16:0] sample_count;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [23:0] mean_q8;
    logic [23:0] std_q8;
    logic        single_sample;
  } sstat_out_t;

  // Accumulator contents handed to the sequencer at the end of a run
  typedef struct packed {
    logic        start;
    logic [16:0] count;
    logic [15:0] min;
    logic [15:0] max;
    logic [31:0] sum;
    logic [47:0] sumsq;
  } sstat_snap_t;

endpackage

[rtl/sstat_alu.sv]
module sstat_alu (
  input  logic [sstat_pkg::ALU_W-1:0] a,
  input  logic [sstat_pkg::ALU_W-1:0] b,
  input  logic                        sub,
  output logic [sstat_pkg::ALU_W-1:0] res,
  output logic                        carry
);
  import sstat_pkg::*;

  logic [ALU_W-1:0] b_inv;

  // On subtract, carry high means a >= b
  always_comb begin
    b_inv        = b ^ {ALU_W{sub}};
    {carry, res} = {1'b0, a} + {1'b0, b_inv} + {{ALU_W{1'b0}}, sub};
  end

endmodule

[rtl/sstat_accum.sv]
module sstat_accum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sstat_pkg::sstat_in_t   in_data,
  input  logic                   seq_busy,
  output sstat_pkg::sstat_snap_t snap
);
  import sstat_pkg::*;

  sstat_in_t   s0_r;
  logic        v0_r;
  logic [31:0] sq_r;
  logic        vsq_r;
  logic        last1_r;
  logic        last2_r;
  logic [16:0] count_r;
  logic [15:0] min_r;
  logic [15:0] max_r;
  logic [31:0] sum_r;
  logic [47:0] sumsq_r;
  logic        accept;
  logic        keep;

  // Hold off new transactions from the end of a run until the result is computed
  assign in_stall = seq_busy | (v0_r & s0_r.last) | last1_r | last2_r;

  always_comb begin
    accept = in_valid & ~in_stall;
    keep   = v0_r && (count_r < MAX_SAMPLES);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_r <= in_data;
    end
    if (v0_r) begin
      sq_r <= 32'(s0_r.sample) * 32'(s0_r.sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      vsq_r   <= 1'b0;
      last1_r <= 1'b0;
      last2_r <= 1'b0;
      count_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
    end else begin
      v0_r    <= accept;
      vsq_r   <= keep;
      last1_r <= v0_r & s0_r.last;
      last2_r <= last1_r;
      if (last2_r) begin
        // Run handed over: return to the empty state
        count_r <= '0;
        min_r   <= '1;
        max_r   <= '0;
        sum_r   <= '0;
        sumsq_r <= '0;
      end else begin
        if (keep) begin
          count_r <= count_r + 17'd1;
          sum_r   <= sum_r + 32'(s0_r.sample);
          if (s0_r.sample < min_r) begin
            min_r <= s0_r.sample;
          end
          if (s0_r.sample > max_r) begin
            max_r <= s0_r.sample;
          end
        end
        if (vsq_r) begin
          sumsq_r <= sumsq_r + 48'(sq_r);
        end
      end
    end
  end

  always_comb begin
    snap.start = last2_r;
    snap.count = count_r;
    snap.min   = min_r;
    snap.max   = max_r;
    snap.sum   = sum_r;
    snap.sumsq = sumsq_r;
  end

endmodule

[rtl/sstat_seq.sv]
module sstat_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sstat_pkg::sstat_snap_t snap,
  output logic                   seq_busy,
  output logic                   res_valid,
  input  logic                   res_stall,
  output sstat_pkg::sstat_out_t  res_data
);
  import sstat_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MEAN = 8'b0000_0010,
    ST_DEN  = 8'b0000_0100,
    ST_NSQ  = 8'b0000_1000,
    ST_SSQ  = 8'b0001_0000,
    ST_VDIV = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [16:0] n_r, n_nxt;
  logic [15:0] min_r, min_nxt;
  logic [15:0] max_r, max_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [47:0] sumsq_r, sumsq_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [23:0] mean_r, mean_nxt;
  logic [23:0] std_r, std_nxt;
  logic        single_r, single_nxt;
  logic        out_valid_r, out_valid_nxt;
  sstat_out_t  out_data_r, out_data_nxt;

  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub, alu_carry;
  logic [33:0]      div_trial;
  logic [33:0]      sq_trial;
  logic [25:0]      sq_test;
  logic             last_iter;

  sstat_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  assign seq_busy  = (state_r != ST_IDLE);
  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

  always_comb begin
    div_trial = {rem_r[32:0], dvd_r[63]};
    sq_trial  = {rem_r[31:0], dvd_r[63:62]};
    sq_test   = {quo_r[23:0], 2'b01};
    last_iter = (cnt_r == 7'd1);

    unique case (state_r)
      ST_MEAN, ST_VDIV: begin
        alu_a   = 64'(div_trial);
        alu_b   = 64'(dvs_r);
        alu_sub = 1'b1;
      end
      ST_DEN: begin
        alu_a   = 64'(dvs_r);
        alu_b   = mcand_r;
        alu_sub = 1'b0;
      end
      ST_SSQ: begin
        alu_a   = acc_r;
        alu_b   = mcand_r;
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = 64'(sq_trial);
        alu_b   = 64'(sq_test);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc_r;
        alu_b   = mcand_r;
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    quo_nxt       = quo_r;
    mean_nxt      = mean_r;
    std_nxt       = std_r;
    single_nxt    = single_r;
    out_data_nxt  = out_data_r;
    // Drop the result once the far side takes it
    out_valid_nxt = out_valid_r & res_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (snap.start) begin
          n_nxt     = snap.count;
          min_nxt   = snap.min;
          max_nxt   = snap.max;
          sum_nxt   = snap.sum;
          sumsq_nxt = snap.sumsq;
          rem_nxt   = '0;
          quo_nxt   = '0;
          dvd_nxt   = {snap.sum, 8'd0, 24'd0};
          dvs_nxt   = 32'(snap.count);
          cnt_nxt   = 7'd40;
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN, ST_VDIV: begin
        rem_nxt = alu_carry ? alu_res[33:0] : div_trial;
        quo_nxt = {quo_r[46:0], alu_carry};
        dvd_nxt = {dvd_r[62:0], 1'b0};
        cnt_nxt = cnt_r - 7'd1;
        if (last_iter) begin
          if (state_r == ST_MEAN) begin
            mean_nxt = quo_nxt[23:0];
            if (n_r < 17'd2) begin
              single_nxt = 1'b1;
              std_nxt    = '0;
              state_nxt  = ST_DONE;
            end else begin
              dvs_nxt    = '0;
              mcand_nxt  = 64'(n_r);
              mplier_nxt = 32'(n_r - 17'd1);
              cnt_nxt    = 7'd17;
              state_nxt  = ST_DEN;
            end
          end else begin
            // Radicand goes to the top of the shift register, two bits a step
            dvd_nxt   = {quo_nxt, 16'd0};
            rem_nxt   = '0;
            quo_nxt   = '0;
            cnt_nxt   = 7'd24;
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_DEN, ST_NSQ, ST_SSQ: begin
        if (mplier_r[0]) begin
          if (state_r == ST_DEN) begin
            dvs_nxt = alu_res[31:0];
          end else begin
            acc_nxt = alu_res;
          end
        end
        mcand_nxt  = {mcand_r[62:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[31:1]};
        cnt_nxt    = cnt_r - 7'd1;
        if (last_iter) begin
          priority case (1'b1)
            state_r == ST_DEN: begin
              acc_nxt    = '0;
              mcand_nxt  = 64'(sumsq_r);
              mplier_nxt = 32'(n_r);
              cnt_nxt    = 7'd17;
              state_nxt  = ST_NSQ;
            end
            state_r == ST_NSQ: begin
              mcand_nxt  = 64'(sum_r);
              mplier_nxt = sum_r;
              cnt_nxt    = 7'd32;
              state_nxt  = ST_SSQ;
            end
            default: begin
              // acc now holds n*sumsq - sum^2; divide it scaled by 2^16
              dvd_nxt   = acc_nxt;
              rem_nxt   = '0;
              quo_nxt   = '0;
              cnt_nxt   = 7'd80;
              state_nxt = ST_VDIV;
            end
          endcase
        end
      end
      ST_SQRT: begin
        rem_nxt = alu_carry ? alu_res[33:0] : sq_trial;
        quo_nxt = {quo_r[46:0], alu_carry};
        dvd_nxt = {dvd_r[61:0], 2'b00};
        cnt_nxt = cnt_r - 7'd1;
        if (last_iter) begin
          std_nxt    = quo_nxt[23:0];
          single_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_nxt) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.sample_count  = n_r;
          out_data_nxt.minimum       = min_r;
          out_data_nxt.maximum       = max_r;
          out_data_nxt.mean_q8       = mean_r;
          out_data_nxt.std_q8        = std_r;
          out_data_nxt.single_sample = single_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    sum_r      <= sum_nxt;
    sumsq_r    <= sumsq_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    dvs_r      <= dvs_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    mean_r     <= mean_nxt;
    std_r      <= std_nxt;
    single_r   <= single_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/sample_statistics_min_max_mean_std.sv]
// Samples that do not end a run are taken one per cycle.
// A sample with last set is followed by a stall while it passes the accumulator pipeline,
// then the shared 64-bit adder runs 40 mean-division steps (all a one-sample run needs),
// else also 66 multiply, 80 deviation-division and 24 square-root steps.
// The result sits in an output register; samples of the next run are taken meanwhile.
// Synchronous active-low reset empties the accumulators and drops any pending result.
module sample_statistics_min_max_mean_std (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sstat_pkg::sstat_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sstat_pkg::sstat_out_t out_data
);
  import sstat_pkg::*;

  sstat_snap_t snap;
  logic        seq_busy;

  sstat_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .seq_busy (seq_busy),
    .snap     (snap)
  );

  sstat_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap      (snap),
    .seq_busy  (seq_busy),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res_data  (out_data)
  );

endmodule
